// File: hw/rtl/pvs_pkg.sv
// ----------------------------------------------------------------------------
// pvs_pkg
// Shared constants, codes and lookup tables of the polyphonic voice synth.
// ----------------------------------------------------------------------------
package pvs_pkg;

    localparam int VOICES_DEF = 16;

    // shared multiplier operand and product widths
    localparam int MUL_AW = 33;
    localparam int MUL_BW = 25;
    localparam int MUL_PW = MUL_AW + MUL_BW;

    localparam logic [2:0] CMD_TICK     = 3'd0;
    localparam logic [2:0] CMD_NOTE_ON  = 3'd1;
    localparam logic [2:0] CMD_NOTE_OFF = 3'd2;
    localparam logic [2:0] CMD_ALL_OFF  = 3'd3;
    localparam logic [2:0] CMD_SET_WAVE = 3'd4;

    localparam logic [2:0] WAVE_SINE   = 3'd0;
    localparam logic [2:0] WAVE_TRI    = 3'd1;
    localparam logic [2:0] WAVE_SAW    = 3'd2;
    localparam logic [2:0] WAVE_SQUARE = 3'd3;
    localparam logic [2:0] WAVE_NOISE  = 3'd4;

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_ATTACK  = 3'd1;
    localparam logic [2:0] ST_DECAY   = 3'd2;
    localparam logic [2:0] ST_SUSTAIN = 3'd3;
    localparam logic [2:0] ST_RELEASE = 3'd4;

    localparam logic [2:0] REG_ATTACK  = 3'd0;
    localparam logic [2:0] REG_DECAY   = 3'd1;
    localparam logic [2:0] REG_RELEASE = 3'd2;
    localparam logic [2:0] REG_SUSTAIN = 3'd3;
    localparam logic [2:0] REG_A4_INC  = 3'd4;
    localparam logic [2:0] REG_GAIN    = 3'd5;

    localparam logic [23:0] RST_ATTACK  = 24'd38043;
    localparam logic [23:0] RST_DECAY   = 24'd713;
    localparam logic [23:0] RST_RELEASE = 24'd740;
    localparam logic [23:0] RST_SUSTAIN = 24'd5872026;
    localparam logic [31:0] RST_A4_INC  = 32'd42852281;
    localparam logic [15:0] RST_GAIN    = 16'd14418;

    localparam logic [23:0] ONE_Q23    = 24'h800000;
    localparam logic [31:0] NOISE_SEED = 32'h9e3779b9;
    localparam logic [31:0] SEED_MUL   = 32'd2654435761;
    localparam logic [16:0] SIN_A      = 17'd102944;
    localparam logic [16:0] SIN_B      = 17'd42047;
    localparam logic [16:0] SIN_C      = 17'd4640;
    localparam logic [15:0] CLIP_END   = 16'd32746;

    function automatic logic [16:0] semitone_ratio(input logic [3:0] semi);
        logic [16:0] r;
        case (semi)
            4'd0:    r = 17'd65536;
            4'd1:    r = 17'd69433;
            4'd2:    r = 17'd73562;
            4'd3:    r = 17'd77936;
            4'd4:    r = 17'd82570;
            4'd5:    r = 17'd87480;
            4'd6:    r = 17'd92682;
            4'd7:    r = 17'd98193;
            4'd8:    r = 17'd104032;
            4'd9:    r = 17'd110218;
            4'd10:   r = 17'd116772;
            4'd11:   r = 17'd123715;
            default: r = 17'd65536;
        endcase
        return r;
    endfunction

    function automatic logic [15:0] tanh_q15(input logic [4:0] idx);
        logic [15:0] y;
        case (idx)
            5'd0:    y = 16'd0;
            5'd1:    y = 16'd8026;
            5'd2:    y = 16'd15143;
            5'd3:    y = 16'd20813;
            5'd4:    y = 16'd24956;
            5'd5:    y = 16'd27797;
            5'd6:    y = 16'd29660;
            5'd7:    y = 16'd30847;
            5'd8:    y = 16'd31589;
            5'd9:    y = 16'd32048;
            5'd10:   y = 16'd32329;
            5'd11:   y = 16'd32501;
            5'd12:   y = 16'd32606;
            5'd13:   y = 16'd32669;
            5'd14:   y = 16'd32708;
            5'd15:   y = 16'd32732;
            default: y = 16'd32746;
        endcase
        return y;
    endfunction

endpackage

// File: hw/rtl/pvs_mul.sv
// ----------------------------------------------------------------------------
// pvs_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module pvs_mul
    import pvs_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_AW-1:0] a,
    input  logic signed [MUL_BW-1:0] b,
    output logic signed [MUL_PW-1:0] p
);

    logic signed [MUL_PW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= MUL_PW'(a) * MUL_PW'(b);
    end

    assign p = p_reg;

endmodule

// File: hw/rtl/polyphonic_voice_synth.sv
// ----------------------------------------------------------------------------
// polyphonic_voice_synth
// Voice synth: note commands, per-voice ADSR and oscillators, soft-clipped mix.
// ----------------------------------------------------------------------------
// One command word is taken at a time; cmd_ready is low while it is worked on.
// Note off, all off and set waveform are done in the idle state. Note on scans
// for the oldest voice when all voices are busy, then computes the increment
// and noise seed and writes the voice. A tick visits every voice through one
// shared multiplier: an idle voice is skipped, an active one steps its envelope
// and oscillator (saw and square with a band-limit correction by a divider,
// one pass for saw and two for square) and adds its term to the mix; gain and
// clip follow. The sample word may wait at the output while the next command
// is taken.
module polyphonic_voice_synth
    import pvs_pkg::*;
#(
    parameter int VOICES = VOICES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_ready,
    input  logic [2:0]         cmd,
    input  logic [6:0]         note,
    input  logic [7:0]         velocity,
    input  logic [2:0]         wave,
    output logic               sample_valid,
    input  logic               sample_ready,
    output logic signed [15:0] sample,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int MIXW = 20 + $clog2(VOICES);
    localparam logic [VW-1:0] LAST = VW'(VOICES - 1);

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_NO_SCAN = 5'd1;
    localparam logic [4:0] S_NO_INC  = 5'd2;
    localparam logic [4:0] S_NO_SEED = 5'd3;
    localparam logic [4:0] S_NO_WR   = 5'd4;
    localparam logic [4:0] S_ENV     = 5'd5;
    localparam logic [4:0] S_OSC     = 5'd6;
    localparam logic [4:0] S_SIN1    = 5'd7;
    localparam logic [4:0] S_SIN2    = 5'd8;
    localparam logic [4:0] S_SIN3    = 5'd9;
    localparam logic [4:0] S_SIN4    = 5'd10;
    localparam logic [4:0] S_SIN5    = 5'd11;
    localparam logic [4:0] S_B0      = 5'd12;
    localparam logic [4:0] S_BDIV    = 5'd13;
    localparam logic [4:0] S_BSQ     = 5'd14;
    localparam logic [4:0] S_BFIN    = 5'd15;
    localparam logic [4:0] S_BNEXT   = 5'd16;
    localparam logic [4:0] S_AMP1    = 5'd17;
    localparam logic [4:0] S_AMP2    = 5'd18;
    localparam logic [4:0] S_AMP3    = 5'd19;
    localparam logic [4:0] S_GAIN    = 5'd20;
    localparam logic [4:0] S_CLIP1   = 5'd21;
    localparam logic [4:0] S_CLIP2   = 5'd22;
    localparam logic [4:0] S_CLIP3   = 5'd23;

    // configuration
    logic [23:0] attack_reg, decay_reg, release_reg, sustain_reg;
    logic [31:0] a4_reg;
    logic [15:0] gain_reg;
    logic [2:0]  wave_reg;
    logic [31:0] counter_reg;

    // voice state
    logic [VOICES-1:0] active_reg;
    logic [6:0]  note_reg  [VOICES];
    logic [31:0] phase_reg [VOICES];
    logic [31:0] inc_reg   [VOICES];
    logic [7:0]  vel_reg   [VOICES];
    logic [23:0] level_reg [VOICES];
    logic [2:0]  stage_reg [VOICES];
    logic [31:0] age_reg   [VOICES];
    logic [31:0] noise_reg [VOICES];

    // sequencer
    logic [4:0]   state_reg;
    logic [VW-1:0] vi_reg, ci_reg;
    logic [31:0]  min_age_reg;
    logic [6:0]   nw_reg;
    logic [7:0]   vw_reg;
    logic [31:0]  ninc_reg;
    logic [23:0]  lv_reg;
    logic [31:0]  ph_reg, dt_reg, bt_reg;
    logic [16:0]  x_reg, x2_reg;
    logic signed [19:0] osc_reg;
    logic signed [17:0] b1_reg, bres_reg;
    logic         pass_reg, bmode_reg;
    logic [33:0]  rem_reg;
    logic [15:0]  quo_reg;
    logic [3:0]   cnt_reg;
    logic signed [MIXW-1:0] mix_reg, cx_reg;
    logic [15:0]  lo_reg;
    logic         sat_reg, neg_reg;
    logic         out_valid_reg;
    logic signed [15:0] sample_reg;

    logic signed [MUL_AW-1:0] mul_a;
    logic signed [MUL_BW-1:0] mul_b;
    logic signed [MUL_PW-1:0] prod;

    pvs_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // free voice search
    logic          free_any;
    logic [VW-1:0] free_idx;
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = VOICES - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_any = 1'b1;
                free_idx = VW'(i);
            end
        end
    end

    // pitch: s = note + 3, octave by reciprocal of 12
    logic [7:0]  pit_s;
    logic [15:0] pit_m;
    logic [3:0]  pit_oct, pit_semi;
    logic [4:0]  pit_sh;
    logic [48:0] pit_shifted;
    assign pit_s       = {1'b0, nw_reg} + 8'd3;
    assign pit_m       = 16'(pit_s) * 16'd171;
    assign pit_oct     = pit_m[14:11];
    assign pit_semi    = 4'(pit_s - 8'(pit_oct) * 8'd12);
    assign pit_sh      = 5'd22 - {1'b0, pit_oct};
    assign pit_shifted = prod[48:0] >> pit_sh;

    // envelope of the current voice
    logic [23:0] sus;
    logic [23:0] env_lv;
    logic [2:0]  env_stage;
    logic        env_kill;
    logic [24:0] att_sum;
    logic [25:0] dec_lim;
    assign sus     = (sustain_reg > ONE_Q23) ? ONE_Q23 : sustain_reg;
    assign att_sum = {1'b0, level_reg[vi_reg]} + {1'b0, attack_reg};
    assign dec_lim = {2'b0, sus} + {2'b0, decay_reg};
    always_comb
    begin
        env_lv    = level_reg[vi_reg];
        env_stage = stage_reg[vi_reg];
        env_kill  = 1'b0;
        case (stage_reg[vi_reg])
            ST_ATTACK:
            begin
                if (att_sum >= {1'b0, ONE_Q23})
                begin
                    env_lv    = ONE_Q23;
                    env_stage = ST_DECAY;
                end
                else
                begin
                    env_lv = att_sum[23:0];
                end
            end
            ST_DECAY:
            begin
                if ({2'b0, level_reg[vi_reg]} <= dec_lim)
                begin
                    env_lv    = sus;
                    env_stage = ST_SUSTAIN;
                end
                else
                begin
                    env_lv = level_reg[vi_reg] - decay_reg;
                end
            end
            ST_RELEASE:
            begin
                if (level_reg[vi_reg] <= release_reg)
                begin
                    env_lv    = '0;
                    env_stage = ST_IDLE;
                    env_kill  = 1'b1;
                end
                else
                begin
                    env_lv = level_reg[vi_reg] - release_reg;
                end
            end
            default: ;
        endcase
    end

    // direct oscillators
    logic [31:0] sq_q, sin_q;
    logic [32:0] tri_d;
    logic signed [19:0] tri_val, saw_base, sq_base, noise_val;
    logic [31:0] nz0, nz1, nz2;
    assign sq_q     = {1'b0, ph_reg[30:0]};
    assign sin_q    = (sq_q > 32'h40000000) ? (32'h80000000 - sq_q) : sq_q;
    assign tri_d    = ph_reg[31] ? {1'b0, ph_reg - 32'h80000000}
                                 : (33'h080000000 - {1'b0, ph_reg});
    assign tri_val  = 20'sd65536 - $signed({1'b0, tri_d[32:14]});
    assign saw_base = $signed({3'b0, ph_reg[31:15]}) - 20'sd65536;
    assign sq_base  = ph_reg[31] ? -20'sd65536 : 20'sd65536;
    assign nz0      = noise_reg[vi_reg] ^ (noise_reg[vi_reg] << 13);
    assign nz1      = nz0 ^ (nz0 >> 17);
    assign nz2      = nz1 ^ (nz1 << 5);
    assign noise_val = $signed({3'b0, nz2[31:15]}) - 20'sd65536;

    // band-limit correction helpers
    logic [32:0] b_rem;
    logic [33:0] div_sh;
    logic        div_ge;
    logic signed [19:0] bcalc;
    assign b_rem  = 33'h100000000 - {1'b0, bt_reg};
    assign div_sh = {rem_reg[32:0], 1'b0};
    assign div_ge = div_sh >= {2'b0, dt_reg};
    always_comb
    begin
        if (!bmode_reg)
            bcalc = $signed({3'b0, quo_reg, 1'b0}) - $signed({4'b0, prod[31:16]})
                    - 20'sd65536;
        else
            bcalc = $signed({4'b0, prod[31:16]}) - $signed({3'b0, quo_reg, 1'b0})
                    + 20'sd65536;
    end

    // sine helpers
    logic [16:0] sin_t3, sin_t4, sin_y;
    assign sin_t3 = SIN_B - 17'(prod[47:16]);
    assign sin_t4 = SIN_A - 17'(prod[47:16]);
    assign sin_y  = (prod[48:16] > 33'd65536) ? 17'd65536 : prod[32:16];

    // per-voice term and clip helpers
    logic signed [MUL_PW-1:0] term_adj, gain_adj;
    logic [MIXW-1:0] clip_a;
    logic [15:0] clip_hi, clip_lo;
    logic        clip_sat;
    logic [15:0] clip_y;
    assign term_adj = (prod + (prod[MUL_PW-1] ? MUL_PW'(32'h7FFFFFFF) : '0)) >>> 31;
    assign gain_adj = (prod + (prod[MUL_PW-1] ? MUL_PW'(32'h0000FFFF) : '0)) >>> 16;
    assign clip_a   = cx_reg[MIXW-1] ? MIXW'(-cx_reg) : MIXW'(cx_reg);
    assign clip_sat = (clip_a >> 14) >= MIXW'(16);
    assign clip_lo  = tanh_q15(5'(clip_a[MIXW-1:14]));
    assign clip_hi  = tanh_q15(5'(clip_a[MIXW-1:14]) + 5'd1);
    assign clip_y   = sat_reg ? CLIP_END : (lo_reg + 16'(prod[29:14]));

    // shared multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_NO_INC:
            begin
                mul_a = $signed({1'b0, a4_reg});
                mul_b = $signed(MUL_BW'(semitone_ratio(pit_semi)));
            end
            S_NO_SEED:
            begin
                mul_a = $signed({1'b0, SEED_MUL});
                mul_b = $signed(MUL_BW'(nw_reg));
            end
            S_SIN1:
            begin
                mul_a = $signed(MUL_AW'(x_reg));
                mul_b = $signed(MUL_BW'(x_reg));
            end
            S_SIN2:
            begin
                mul_a = $signed(MUL_AW'(SIN_C));
                mul_b = $signed(MUL_BW'(prod[32:16]));
            end
            S_SIN3:
            begin
                mul_a = $signed(MUL_AW'(sin_t3));
                mul_b = $signed(MUL_BW'(x2_reg));
            end
            S_SIN4:
            begin
                mul_a = $signed(MUL_AW'(sin_t4));
                mul_b = $signed(MUL_BW'(x_reg));
            end
            S_BSQ:
            begin
                mul_a = $signed(MUL_AW'(quo_reg));
                mul_b = $signed(MUL_BW'(quo_reg));
            end
            S_AMP1:
            begin
                mul_a = MUL_AW'(osc_reg);
                mul_b = $signed(MUL_BW'(vel_reg[vi_reg]));
            end
            S_AMP2:
            begin
                mul_a = prod[MUL_AW-1:0];
                mul_b = $signed(MUL_BW'(lv_reg));
            end
            S_GAIN:
            begin
                mul_a = MUL_AW'(mix_reg);
                mul_b = $signed(MUL_BW'(gain_reg));
            end
            S_CLIP2:
            begin
                mul_a = $signed(MUL_AW'(clip_hi - clip_lo));
                mul_b = $signed(MUL_BW'(clip_a[13:0]));
            end
            default: ;
        endcase
    end

    logic cmd_acc;
    assign cmd_acc   = cmd_valid && cmd_ready;
    assign cmd_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg    <= RST_ATTACK;
            decay_reg     <= RST_DECAY;
            release_reg   <= RST_RELEASE;
            sustain_reg   <= RST_SUSTAIN;
            a4_reg        <= RST_A4_INC;
            gain_reg      <= RST_GAIN;
            wave_reg      <= WAVE_SAW;
            counter_reg   <= '0;
            active_reg    <= '0;
            state_reg     <= S_IDLE;
            vi_reg        <= '0;
            ci_reg        <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < VOICES; i++)
            begin
                note_reg[i]  <= '0;
                phase_reg[i] <= '0;
                inc_reg[i]   <= '0;
                vel_reg[i]   <= '0;
                level_reg[i] <= '0;
                stage_reg[i] <= ST_IDLE;
                age_reg[i]   <= '0;
                noise_reg[i] <= NOISE_SEED;
            end
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_ATTACK:  attack_reg  <= cfg_data[23:0];
                    REG_DECAY:   decay_reg   <= cfg_data[23:0];
                    REG_RELEASE: release_reg <= cfg_data[23:0];
                    REG_SUSTAIN: sustain_reg <= cfg_data[23:0];
                    REG_A4_INC:  a4_reg      <= cfg_data;
                    REG_GAIN:    gain_reg    <= cfg_data[15:0];
                    default: ;
                endcase
            end

            // in the last clip cycle the output register is handled there
            if (sample_valid && sample_ready && state_reg != S_CLIP3)
                out_valid_reg <= 1'b0;

            case (state_reg)
                S_IDLE:
                begin
                    if (cmd_acc)
                    begin
                        case (cmd)
                            CMD_TICK:
                            begin
                                vi_reg    <= '0;
                                mix_reg   <= '0;
                                state_reg <= S_ENV;
                            end
                            CMD_NOTE_ON:
                            begin
                                nw_reg <= note;
                                vw_reg <= velocity;
                                if (free_any)
                                begin
                                    ci_reg    <= free_idx;
                                    state_reg <= S_NO_INC;
                                end
                                else
                                begin
                                    ci_reg      <= '0;
                                    min_age_reg <= age_reg[0];
                                    vi_reg      <= VW'(1);
                                    state_reg   <= (VOICES > 1) ? S_NO_SCAN : S_NO_INC;
                                end
                            end
                            CMD_NOTE_OFF:
                            begin
                                for (int i = 0; i < VOICES; i++)
                                    if (active_reg[i] && note_reg[i] == note)
                                        stage_reg[i] <= ST_RELEASE;
                            end
                            CMD_ALL_OFF:
                            begin
                                for (int i = 0; i < VOICES; i++)
                                    if (active_reg[i])
                                        stage_reg[i] <= ST_RELEASE;
                            end
                            CMD_SET_WAVE: wave_reg <= wave;
                            default: ;
                        endcase
                    end
                end
                S_NO_SCAN:
                begin
                    if (age_reg[vi_reg] < min_age_reg)
                    begin
                        ci_reg      <= vi_reg;
                        min_age_reg <= age_reg[vi_reg];
                    end
                    if (vi_reg == LAST)
                        state_reg <= S_NO_INC;
                    else
                        vi_reg <= vi_reg + VW'(1);
                end
                S_NO_INC: state_reg <= S_NO_SEED;
                S_NO_SEED:
                begin
                    ninc_reg  <= (|pit_shifted[48:32]) ? 32'hFFFFFFFF : pit_shifted[31:0];
                    state_reg <= S_NO_WR;
                end
                S_NO_WR:
                begin
                    note_reg[ci_reg]   <= nw_reg;
                    phase_reg[ci_reg]  <= '0;
                    inc_reg[ci_reg]    <= ninc_reg;
                    vel_reg[ci_reg]    <= vw_reg;
                    level_reg[ci_reg]  <= '0;
                    noise_reg[ci_reg]  <= NOISE_SEED + prod[31:0] + counter_reg;
                    stage_reg[ci_reg]  <= ST_ATTACK;
                    age_reg[ci_reg]    <= counter_reg + 32'd1;
                    active_reg[ci_reg] <= 1'b1;
                    counter_reg        <= counter_reg + 32'd1;
                    state_reg          <= S_IDLE;
                end
                S_ENV:
                begin
                    if (!active_reg[vi_reg])
                    begin
                        if (vi_reg == LAST)
                            state_reg <= S_GAIN;
                        else
                            vi_reg <= vi_reg + VW'(1);
                    end
                    else
                    begin
                        level_reg[vi_reg] <= env_lv;
                        stage_reg[vi_reg] <= env_stage;
                        if (env_kill)
                            active_reg[vi_reg] <= 1'b0;
                        lv_reg    <= env_lv;
                        ph_reg    <= phase_reg[vi_reg];
                        dt_reg    <= inc_reg[vi_reg];
                        state_reg <= S_OSC;
                    end
                end
                S_OSC:
                begin
                    pass_reg <= 1'b0;
                    bt_reg   <= ph_reg;
                    x_reg    <= sin_q[30:14];
                    case (wave_reg)
                        WAVE_SINE:   state_reg <= S_SIN1;
                        WAVE_TRI:
                        begin
                            osc_reg   <= tri_val;
                            state_reg <= S_AMP1;
                        end
                        WAVE_SAW:    state_reg <= S_B0;
                        WAVE_SQUARE: state_reg <= S_B0;
                        WAVE_NOISE:
                        begin
                            noise_reg[vi_reg] <= nz2;
                            osc_reg           <= noise_val;
                            state_reg         <= S_AMP1;
                        end
                        default:
                        begin
                            osc_reg   <= '0;
                            state_reg <= S_AMP1;
                        end
                    endcase
                end
                S_SIN1: state_reg <= S_SIN2;
                S_SIN2:
                begin
                    x2_reg    <= prod[32:16];
                    state_reg <= S_SIN3;
                end
                S_SIN3: state_reg <= S_SIN4;
                S_SIN4: state_reg <= S_SIN5;
                S_SIN5:
                begin
                    osc_reg   <= ph_reg[31] ? -$signed({3'b0, sin_y}) : $signed({3'b0, sin_y});
                    state_reg <= S_AMP1;
                end
                S_B0:
                begin
                    cnt_reg <= '0;
                    quo_reg <= '0;
                    if (dt_reg == '0)
                    begin
                        bres_reg  <= '0;
                        state_reg <= S_BNEXT;
                    end
                    else if (bt_reg < dt_reg)
                    begin
                        rem_reg   <= {2'b0, bt_reg};
                        bmode_reg <= 1'b0;
                        state_reg <= S_BDIV;
                    end
                    else if (b_rem < {1'b0, dt_reg})
                    begin
                        rem_reg   <= {1'b0, b_rem};
                        bmode_reg <= 1'b1;
                        state_reg <= S_BDIV;
                    end
                    else
                    begin
                        bres_reg  <= '0;
                        state_reg <= S_BNEXT;
                    end
                end
                S_BDIV:
                begin
                    // one quotient bit a cycle, remainder stays below dt
                    rem_reg <= div_ge ? (div_sh - {2'b0, dt_reg}) : div_sh;
                    quo_reg <= {quo_reg[14:0], div_ge};
                    cnt_reg <= cnt_reg + 4'd1;
                    if (cnt_reg == 4'd15)
                        state_reg <= S_BSQ;
                end
                S_BSQ: state_reg <= S_BFIN;
                S_BFIN:
                begin
                    bres_reg  <= 18'(bcalc);
                    state_reg <= S_BNEXT;
                end
                S_BNEXT:
                begin
                    if (wave_reg == WAVE_SAW)
                    begin
                        osc_reg   <= saw_base - 20'(bres_reg);
                        state_reg <= S_AMP1;
                    end
                    else if (!pass_reg)
                    begin
                        b1_reg    <= bres_reg;
                        pass_reg  <= 1'b1;
                        bt_reg    <= ph_reg + 32'h80000000;
                        state_reg <= S_B0;
                    end
                    else
                    begin
                        osc_reg   <= sq_base + 20'(b1_reg) - 20'(bres_reg);
                        state_reg <= S_AMP1;
                    end
                end
                S_AMP1: state_reg <= S_AMP2;
                S_AMP2: state_reg <= S_AMP3;
                S_AMP3:
                begin
                    mix_reg           <= mix_reg + MIXW'(term_adj);
                    phase_reg[vi_reg] <= ph_reg + dt_reg;
                    if (vi_reg == LAST)
                        state_reg <= S_GAIN;
                    else
                    begin
                        vi_reg    <= vi_reg + VW'(1);
                        state_reg <= S_ENV;
                    end
                end
                S_GAIN: state_reg <= S_CLIP1;
                S_CLIP1:
                begin
                    cx_reg    <= MIXW'(gain_adj);
                    state_reg <= S_CLIP2;
                end
                S_CLIP2:
                begin
                    lo_reg    <= clip_lo;
                    sat_reg   <= clip_sat;
                    neg_reg   <= cx_reg[MIXW-1];
                    state_reg <= S_CLIP3;
                end
                S_CLIP3:
                begin
                    // hold until the previous sample word is taken
                    if (!sample_valid || sample_ready)
                    begin
                        sample_reg    <= neg_reg ? -$signed(clip_y) : $signed(clip_y);
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign sample_valid = out_valid_reg;
    assign sample       = sample_reg;

    a_voice_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (vi_reg <= LAST))
        else $error("voice index out of range");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg[vi_reg] |-> (level_reg[vi_reg] <= ONE_Q23))
        else $error("envelope level above one");

    a_note_on_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NO_WR) |=> active_reg[$past(ci_reg)])
        else $error("note on left voice inactive");

    a_sample_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(sample_valid) |-> $past(state_reg == S_CLIP3))
        else $error("sample word without a tick");

endmodule
